// ----- hdl/irss_pkg.sv -----
// Shared types and constants for the indexed ring sequence store.
// Used by irss_cell, irss_ctrl and the top level; no dependencies.
package irss_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int POS_W      = 8;
  localparam int OP_W       = 4;

  typedef enum logic [OP_W-1:0] {
    OP_GET         = 4'd0,
    OP_PUT         = 4'd1,
    OP_ADD_HIGH    = 4'd2,
    OP_ADD_LOW     = 4'd3,
    OP_ADD_AT      = 4'd4,
    OP_REMOVE_AT   = 4'd5,
    OP_REMOVE_HIGH = 4'd6,
    OP_REMOVE_LOW  = 4'd7,
    OP_ROTATE      = 4'd8,
    OP_CLEAR       = 4'd9
  } opcode_t;

  // What every cell does under the broadcast command
  typedef enum logic [2:0] {
    CM_HOLD = 3'd0,
    CM_PUT  = 3'd1,
    CM_INS  = 3'd2,
    CM_DEL  = 3'd3,
    CM_ROT  = 3'd4
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t            mode;
    logic [IDX_W-1:0]      tgt;
    logic [IDX_W-1:0]      last;
    logic [DATA_WIDTH-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    logic             ok;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    cell_mode_t       mode;
    logic [IDX_W-1:0] tgt;
    logic [CNT_W-1:0] cnt_nxt;
    logic [IDX_W-1:0] rot_k;
  } dec_t;

endpackage

// ----- hdl/indexed_ring_sequence_store_unit.sv -----
// Indexed ring sequence store: a chain of word cells with a decoder.
// The input word is decoded in the execute state, which commits into the
// result register; no new input word is taken until the operation is done.
// A rotate by k places then steps the chain one place a cycle, and a result word
// not yet taken holds the next operation until it leaves. Synchronous
// active-low reset empties the ring; cell contents are not cleared.
// Depends on irss_pkg, irss_cell and irss_ctrl.
module indexed_ring_sequence_store_unit
  import irss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] opcode, [11:4] position, [43:12] value, [47:44] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [32:1] word_out, [39:33] count, [40] empty_res, [47:41] zero
  output logic [47:0] out_tdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_ROT  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [OP_W-1:0]       op_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      rot_r, rot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [47:0]           out_data_r;

  dec_t                  dec;
  cell_cmd_t             cmd;
  logic                  exec_go;
  logic [CNT_W-1:0]      last_w;
  logic [DATA_WIDTH-1:0] words [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;

  irss_ctrl u_ctrl (
    .op    (op_r),
    .pos   (pos_r),
    .value (val_r),
    .cnt   (cnt_r),
    .dec   (dec)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[g+1];
    end
    irss_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .head_word  (words[0]),
      .word       (words[g])
    );
  end

  assign in_tready = (state_r == ST_IDLE);
  // the result register must be free before an operation commits
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign last_w    = cnt_r - CNT_W'(1);
  assign rd_word   = words[dec.rd_idx];

  always_comb begin
    cmd.mode  = CM_HOLD;
    cmd.tgt   = dec.tgt;
    cmd.last  = last_w[IDX_W-1:0];
    cmd.value = val_r;
    if (exec_go && dec.ok) cmd.mode = dec.mode;
    else if (state_r == ST_ROT) cmd.mode = CM_ROT;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rot_nxt       = rot_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) begin
          out_valid_nxt = 1'b1;
          cnt_nxt       = dec.cnt_nxt;
          rot_nxt       = dec.rot_k;
          if (dec.ok && op_r == OP_ROTATE && dec.rot_k != '0) state_nxt = ST_ROT;
          else state_nxt = ST_IDLE;
        end
      end
      ST_ROT: begin
        rot_nxt = rot_r - IDX_W'(1);
        if (rot_r == IDX_W'(1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the accepted word and build the result word
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r  <= in_tdata[3:0];
      pos_r <= in_tdata[11:4];
      val_r <= in_tdata[43:12];
    end
    if (exec_go) begin
      out_data_r[0]     <= dec.ok;
      out_data_r[32:1]  <= (dec.ok && dec.rd_en) ? rd_word : '0;
      out_data_r[39:33] <= dec.cnt_nxt;
      out_data_r[40]    <= (dec.cnt_nxt == '0);
      out_data_r[47:41] <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an operation is in flight");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40] == (out_tdata[39:33] == '0)))
    else $error("empty flag disagrees with count");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[32:1] == '0))
    else $error("failed operation returned a nonzero word");

endmodule

// ----- hdl/irss_cell.sv -----
// One storage cell of the ring chain: holds a word and takes it from a
// neighbour, the head or the input value as the broadcast command says.
// Depends on irss_pkg.
module irss_cell
  import irss_pkg::*;
(
  input  logic                  clk,
  input  logic [IDX_W-1:0]      idx,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] head_word,
  output logic [DATA_WIDTH-1:0] word
);

  logic [DATA_WIDTH-1:0] word_r;
  logic [DATA_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    case (cmd.mode)
      CM_PUT: begin
        if (idx == cmd.tgt) word_nxt = cmd.value;
      end
      CM_INS: begin
        if (idx > cmd.tgt) word_nxt = left_word;
        else if (idx == cmd.tgt) word_nxt = cmd.value;
      end
      CM_DEL: begin
        if (idx >= cmd.tgt) word_nxt = right_word;
      end
      CM_ROT: begin
        // advance one place towards the head; the old head wraps to the end
        if (idx == cmd.last) word_nxt = head_word;
        else if (idx < cmd.last) word_nxt = right_word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ----- hdl/irss_ctrl.sv -----
// Operation decoder: checks positions and fill level, picks the cell
// command, read index, new count and rotation length. Depends on irss_pkg.
module irss_ctrl
  import irss_pkg::*;
(
  input  logic [OP_W-1:0]       op,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [CNT_W-1:0]      cnt,
  output dec_t                  dec
);

  logic signed [POS_W:0] p;
  logic signed [POS_W:0] nn;
  logic signed [POS_W:0] ins9;
  logic signed [POS_W:0] k9;
  logic                  idx_ok;
  logic                  w_nz;
  logic                  can_add;
  logic                  not_empty;
  logic [CNT_W-1:0]      cnt_p1;
  logic [CNT_W-1:0]      cnt_m1;

  always_comb begin
    p         = {pos[POS_W-1], pos};
    nn        = {{(POS_W+1-CNT_W){1'b0}}, cnt};
    idx_ok    = (p >= 0) && (p < nn);
    w_nz      = (value != '0);
    can_add   = w_nz && (cnt < CNT_W'(CAPACITY));
    not_empty = (cnt != '0);
    cnt_p1    = cnt + CNT_W'(1);
    cnt_m1    = cnt - CNT_W'(1);

    if (p == 1 || p == -nn) ins9 = '0;
    else if (p == 0 || p == nn + 1) ins9 = nn;
    else if (p < 0) ins9 = p + nn;
    else ins9 = p - 9'sd1;

    if (p < 0) k9 = p + nn;
    else if (p == nn) k9 = '0;
    else k9 = p;

    dec         = '0;
    dec.mode    = CM_HOLD;
    dec.cnt_nxt = cnt;
    case (op)
      OP_GET: begin
        dec.ok     = idx_ok;
        dec.rd_en  = 1'b1;
        dec.rd_idx = pos[IDX_W-1:0];
      end
      OP_PUT: begin
        dec.ok     = idx_ok && w_nz;
        dec.rd_en  = 1'b1;
        dec.rd_idx = pos[IDX_W-1:0];
        dec.mode   = CM_PUT;
        dec.tgt    = pos[IDX_W-1:0];
      end
      OP_ADD_HIGH: begin
        dec.ok   = can_add;
        dec.mode = CM_INS;
        dec.tgt  = cnt[IDX_W-1:0];
      end
      OP_ADD_LOW: begin
        dec.ok   = can_add;
        dec.mode = CM_INS;
        dec.tgt  = '0;
      end
      OP_ADD_AT: begin
        dec.ok   = can_add && (p >= -nn) && (p <= nn + 1);
        dec.mode = CM_INS;
        dec.tgt  = ins9[IDX_W-1:0];
      end
      OP_REMOVE_AT: begin
        dec.ok     = idx_ok;
        dec.rd_en  = 1'b1;
        dec.rd_idx = pos[IDX_W-1:0];
        dec.mode   = CM_DEL;
        dec.tgt    = pos[IDX_W-1:0];
      end
      OP_REMOVE_HIGH: begin
        dec.ok     = not_empty;
        dec.rd_en  = 1'b1;
        dec.rd_idx = cnt_m1[IDX_W-1:0];
        dec.mode   = CM_DEL;
        dec.tgt    = cnt_m1[IDX_W-1:0];
      end
      OP_REMOVE_LOW: begin
        dec.ok     = not_empty;
        dec.rd_en  = 1'b1;
        dec.rd_idx = '0;
        dec.mode   = CM_DEL;
        dec.tgt    = '0;
      end
      OP_ROTATE: begin
        dec.ok    = not_empty && (p >= -nn) && (p <= nn);
        dec.rot_k = k9[IDX_W-1:0];
      end
      OP_CLEAR: begin
        dec.ok = 1'b1;
      end
      default: dec.ok = 1'b0;
    endcase

    if (dec.ok) begin
      if (dec.mode == CM_INS) dec.cnt_nxt = cnt_p1;
      else if (dec.mode == CM_DEL) dec.cnt_nxt = cnt_m1;
      else if (op == OP_CLEAR) dec.cnt_nxt = '0;
    end
  end

endmodule
